FILE: rtl/core/tmsr_pkg.sv
// Shared types, constants and helpers for the text-mode scanline renderer.
// Every other file of the core refers to this package by scoped names.
package tmsr_pkg;

    // Geometry of the screen store and font store
    localparam int MAX_ROWS     = 64;
    localparam int MAX_COLS     = 128;
    localparam int FIRST_GLYPH  = 32;
    localparam int GLYPH_COUNT  = 96;
    localparam int ROW_W        = 6;
    localparam int COL_W        = 7;
    localparam int CHAR_ROW_W   = 7;
    localparam int SCREEN_AW    = ROW_W + COL_W;
    localparam int SCREEN_DEPTH = MAX_ROWS * MAX_COLS;
    localparam int GLYPH_IW     = 7;
    localparam int FONT_AW      = GLYPH_IW + 3;
    localparam int FONT_DEPTH   = GLYPH_COUNT * 8;

    localparam logic [8:0] MAX_ROWS_V    = 9'(MAX_ROWS);
    localparam logic [8:0] MAX_COLS_V    = 9'(MAX_COLS);
    localparam logic [7:0] SPACE_CODE    = 8'd32;
    localparam logic [SCREEN_AW-1:0] SCREEN_LAST = SCREEN_AW'(SCREEN_DEPTH - 1);

    // Request function codes
    localparam logic [1:0] FUNC_SCREEN_WR = 2'd0;
    localparam logic [1:0] FUNC_FONT_WR   = 2'd1;
    localparam logic [1:0] FUNC_RENDER    = 2'd2;

    // Configuration register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_COLOR  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_COLOR    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_COLS_IN_USE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS_IN_USE = 3'd4;

    // Byte orderings of the serialiser
    localparam logic [2:0] NORMAL_ORDER [8] = '{3'd2, 3'd3, 3'd0, 3'd1,
                                                3'd6, 3'd7, 3'd4, 3'd5};
    localparam logic [2:0] DOUBLE_ORDER [16] = '{3'd1, 3'd1, 3'd0, 3'd0,
                                                 3'd3, 3'd3, 3'd2, 3'd2,
                                                 3'd5, 3'd5, 3'd4, 3'd4,
                                                 3'd7, 3'd7, 3'd6, 3'd6};

    typedef struct packed {
        logic [1:0] func;
        logic [5:0] cell_row;
        logic [6:0] cell_col;
        logic [7:0] char_code;
        logic [2:0] glyph_row;
        logic [7:0] glyph_bits;
        logic [9:0] scan_line;
    } in_item_t;

    typedef struct packed {
        logic [63:0] pixels;
        logic        last;
    } out_item_t;

    // Controller to datapath
    typedef struct packed {
        logic clear_step;
        logic screen_wr;
        logic font_wr;
        logic render;
        logic font_rd;
        logic load_out;
        logic second_half;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic clear_last;
        logic out_free;
        logic double_mode;
    } status_t;

    // True when a code has a glyph in the font store
    function automatic logic in_glyph_range(input logic [7:0] code);
        return (9'(code) >= 9'(FIRST_GLYPH)) &&
               (9'(code) < 9'(FIRST_GLYPH + GLYPH_COUNT));
    endfunction

endpackage

FILE: rtl/core/text_mode_scanline_renderer_core.sv
// Top level of the text-mode scanline renderer: controller and datapath.
// Depends on tmsr_pkg, tmsr_ctrl and tmsr_datapath.
//
// After reset the block sweeps its 8192-entry screen store with spaces, one
// entry a cycle, and takes no request until the sweep ends; configuration
// writes are taken throughout. A screen or font write request is done in the
// idle state that accepts it. A render request reads the screen store, then
// reads the font store with the code found there, then colours, orders and
// registers the pixels of each result: one result in normal mode and two in
// double-size mode, each waiting until the output register is free.
// A result waits in the output register while the next request is accepted.
// Configuration writes take effect at once.
module text_mode_scanline_renderer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  tmsr_pkg::in_item_t             s_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tmsr_pkg::out_item_t            m_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data
);

    tmsr_pkg::cmd_t    cmd;
    tmsr_pkg::status_t st;

    tmsr_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_func  (s_data.func),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    tmsr_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .st        (st)
    );

endmodule

FILE: rtl/core/tmsr_ctrl.sv
// Sequencer of the renderer: clearing pass, request decode, fetch and emit steps.
// Depends on tmsr_pkg for the command and status structs and function codes.
module tmsr_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic [1:0]       s_func,
    output logic             s_ready,
    input  tmsr_pkg::status_t st,
    output tmsr_pkg::cmd_t    cmd
);

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_FETCH = 5'b00100,
        ST_EMIT1 = 5'b01000,
        ST_EMIT2 = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Decode state and request into commands
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        unique case (state_reg)
            ST_CLEAR: begin
                cmd.clear_step = 1'b1;
                if (st.clear_last) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.screen_wr = (s_func == tmsr_pkg::FUNC_SCREEN_WR);
                    cmd.font_wr   = (s_func == tmsr_pkg::FUNC_FONT_WR);
                    cmd.render    = (s_func == tmsr_pkg::FUNC_RENDER);
                    if (s_func == tmsr_pkg::FUNC_RENDER) begin
                        state_next = ST_FETCH;
                    end
                end
            end
            ST_FETCH: begin
                cmd.font_rd = 1'b1;
                state_next  = ST_EMIT1;
            end
            ST_EMIT1: begin
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = st.double_mode ? ST_EMIT2 : ST_IDLE;
                end
            end
            ST_EMIT2: begin
                cmd.second_half = 1'b1;
                if (st.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Advance state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    // A result is never loaded over one still waiting downstream
    a_load_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> st.out_free)
        else $error("result loaded while output register busy");

    // Double-size first half always moves on to the second half
    a_double_two: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_EMIT1 && st.out_free && st.double_mode)
            |=> (state_reg == ST_EMIT2))
        else $error("double-size request lost its second result");

    // Leaving reset always starts the clearing pass
    a_reset_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> (state_reg == ST_CLEAR))
        else $error("clearing pass skipped after reset");

    // Clearing pass holds until the final entry is written
    a_clear_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_CLEAR && !st.clear_last) |=> (state_reg == ST_CLEAR))
        else $error("clearing pass ended early");

endmodule

FILE: rtl/core/tmsr_datapath.sv
// Datapath of the renderer: configuration registers, screen and font stores,
// glyph lookup, pixel serialiser and output register. Depends on tmsr_pkg.
module tmsr_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tmsr_pkg::in_item_t             s_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [tmsr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]                     cfg_data,
    output logic                           m_valid,
    input  logic                           m_ready,
    output tmsr_pkg::out_item_t            m_data,
    input  tmsr_pkg::cmd_t                 cmd,
    output tmsr_pkg::status_t              st
);

    // Configuration registers
    logic [7:0] text_color_reg;
    logic [7:0] bg_color_reg;
    logic       double_size_reg;
    logic [7:0] cols_in_use_reg;
    logic [6:0] rows_in_use_reg;

    // Stores and pipeline registers
    logic [7:0] screen_mem [tmsr_pkg::SCREEN_DEPTH];
    logic [7:0] font_mem   [tmsr_pkg::FONT_DEPTH];
    logic [tmsr_pkg::SCREEN_AW-1:0] clr_cnt_reg;
    logic [7:0] screen_q_reg;
    logic       in_area_reg;
    logic [2:0] pix_row_reg;
    logic [7:0] font_q_reg;
    logic       bits_ok_reg;
    logic       m_valid_reg;
    tmsr_pkg::out_item_t m_data_reg;
    tmsr_pkg::out_item_t out_next;

    logic [tmsr_pkg::CHAR_ROW_W-1:0] char_row;
    logic [2:0]                      pix_row;
    logic                            in_area;
    logic [tmsr_pkg::SCREEN_AW-1:0]  wr_addr;
    logic [tmsr_pkg::SCREEN_AW-1:0]  rd_addr;
    logic                            wr_in_range;
    logic                            code_ok;
    logic [7:0]                      code_eff;
    logic [7:0]                      glyph_off;
    logic [7:0]                      font_wr_off;
    logic [tmsr_pkg::FONT_AW-1:0]    font_rd_addr;
    logic [tmsr_pkg::FONT_AW-1:0]    font_wr_addr;
    logic [7:0]                      bits;
    logic [7:0]                      px [8];

    assign cfg_ready = 1'b1;

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            text_color_reg  <= 8'd31;
            bg_color_reg    <= 8'd3;
            double_size_reg <= 1'b0;
            cols_in_use_reg <= 8'd80;
            rows_in_use_reg <= 7'd60;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                tmsr_pkg::CFG_TEXT_COLOR:  text_color_reg  <= cfg_data;
                tmsr_pkg::CFG_BG_COLOR:    bg_color_reg    <= cfg_data;
                tmsr_pkg::CFG_DOUBLE_SIZE: double_size_reg <= cfg_data[0];
                tmsr_pkg::CFG_COLS_IN_USE: cols_in_use_reg <= cfg_data;
                tmsr_pkg::CFG_ROWS_IN_USE: rows_in_use_reg <= cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    // Sweep the screen store with spaces after reset
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_cnt_reg <= '0;
        end else if (cmd.clear_step) begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // Locate the character cell of a render request
    always_comb begin
        char_row = double_size_reg ? {1'b0, s_data.scan_line[9:4]}
                                   : s_data.scan_line[9:3];
        pix_row  = double_size_reg ? s_data.scan_line[3:1] : s_data.scan_line[2:0];
        in_area  = (9'(char_row) < 9'(rows_in_use_reg)) &&
                   (9'(char_row) < tmsr_pkg::MAX_ROWS_V) &&
                   (9'(s_data.cell_col) < 9'(cols_in_use_reg)) &&
                   (9'(s_data.cell_col) < tmsr_pkg::MAX_COLS_V);
        rd_addr  = {char_row[tmsr_pkg::ROW_W-1:0], s_data.cell_col};
        wr_addr  = {s_data.cell_row, s_data.cell_col};
        wr_in_range = (9'(s_data.cell_row) < tmsr_pkg::MAX_ROWS_V) &&
                      (9'(s_data.cell_col) < tmsr_pkg::MAX_COLS_V);
    end

    // Screen store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.clear_step) begin
            screen_mem[clr_cnt_reg] <= tmsr_pkg::SPACE_CODE;
        end else if (cmd.screen_wr && wr_in_range) begin
            screen_mem[wr_addr] <= s_data.char_code;
        end
        if (cmd.render) begin
            screen_q_reg <= screen_mem[rd_addr];
            in_area_reg  <= in_area;
            pix_row_reg  <= pix_row;
        end
    end

    // Map the stored code to a font address, substituting a space
    always_comb begin
        code_ok      = tmsr_pkg::in_glyph_range(screen_q_reg);
        code_eff     = code_ok ? screen_q_reg : tmsr_pkg::SPACE_CODE;
        glyph_off    = code_eff - 8'(tmsr_pkg::FIRST_GLYPH);
        font_rd_addr = {glyph_off[tmsr_pkg::GLYPH_IW-1:0], pix_row_reg};
        font_wr_off  = s_data.char_code - 8'(tmsr_pkg::FIRST_GLYPH);
        font_wr_addr = {font_wr_off[tmsr_pkg::GLYPH_IW-1:0], s_data.glyph_row};
    end

    // Font store: one write port, registered read
    always_ff @(posedge aclk) begin
        if (cmd.font_wr && tmsr_pkg::in_glyph_range(s_data.char_code)) begin
            font_mem[font_wr_addr] <= s_data.glyph_bits;
        end
        if (cmd.font_rd) begin
            font_q_reg  <= font_mem[font_rd_addr];
            bits_ok_reg <= in_area_reg &&
                           (code_ok || tmsr_pkg::in_glyph_range(tmsr_pkg::SPACE_CODE));
        end
    end

    // Colour the glyph bits and serialise them in output order
    always_comb begin
        logic [2:0] sel;
        sel  = '0;
        bits = bits_ok_reg ? font_q_reg : 8'd0;
        for (int k = 0; k < 8; k++) begin
            px[k] = bits[7 - k] ? text_color_reg : bg_color_reg;
        end
        for (int k = 0; k < 8; k++) begin
            if (!double_size_reg) begin
                sel = tmsr_pkg::NORMAL_ORDER[k];
            end else if (cmd.second_half) begin
                sel = tmsr_pkg::DOUBLE_ORDER[k + 8];
            end else begin
                sel = tmsr_pkg::DOUBLE_ORDER[k];
            end
            out_next.pixels[8*k +: 8] = px[sel];
        end
        out_next.last = !double_size_reg || cmd.second_half;
    end

    // Hold the result until the downstream side takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            m_data_reg <= out_next;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_data         = m_data_reg;
    assign st.clear_last  = (clr_cnt_reg == tmsr_pkg::SCREEN_LAST);
    assign st.out_free    = !m_valid_reg || m_ready;
    assign st.double_mode = double_size_reg;

endmodule
